>>> src/npyhdp_pkg.sv
// ----------------------------------------------------------------------------
// npyhdp_pkg
// Shared types and character constants for the header dictionary parser.
// ----------------------------------------------------------------------------
package npyhdp_pkg;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_EIGHT  = 8'h38;

   localparam int unsigned KEY_LEN = 5;

   localparam logic [1:0] ELEM_UNKNOWN = 2'd0;
   localparam logic [1:0] ELEM_INT64   = 2'd1;
   localparam logic [1:0] ELEM_FLOAT64 = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_DESCR = 2'd1,
      KIND_SHAPE = 2'd2,
      KIND_MISS  = 2'd3
   } key_kind_type;

   typedef struct packed {
      logic [1:0]  element_type;
      logic [31:0] row_count;
      logic [31:0] col_count;
      logic        dict_closed;
   } result_type;

   function automatic logic [7:0] key_byte(input key_kind_type kind, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (pos)
         3'd0: ch = (kind == KIND_DESCR) ? 8'h64 : 8'h73;
         3'd1: ch = (kind == KIND_DESCR) ? 8'h65 : 8'h68;
         3'd2: ch = (kind == KIND_DESCR) ? 8'h73 : 8'h61;
         3'd3: ch = (kind == KIND_DESCR) ? 8'h63 : 8'h70;
         3'd4: ch = (kind == KIND_DESCR) ? 8'h72 : 8'h65;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> src/npy_header_dict_parser.sv
// ----------------------------------------------------------------------------
// npy_header_dict_parser
// Reads a NumPy header dictionary byte by byte and reports type and shape.
//
//   Channel   Direction  Contents
//   req_      in         one header byte, tlast on the final byte
//   rsp_      out        element type, rows and cols; tuser is dict_closed
//
// One byte is taken per cycle while req_tready is high; the parse state updates in the same cycle.
// The result is registered and appears in the cycle after the byte marked last is accepted.
// Reset is synchronous and returns the parser to waiting for the brace.
// A stalled result stalls input only while the result register is full.
// ----------------------------------------------------------------------------
module npy_header_dict_parser #(
   parameter int unsigned TOKEN_MAX = 99,
   parameter int unsigned DIM_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] header_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] element_type, [33:2] row_count, [65:34] col_count
   output logic [0:0]  rsp_tuser    // [0] dict_closed
);

   npyhdp_pkg::result_type result;
   npyhdp_pkg::result_type rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   npyhdp_core #(
      .TOKEN_MAX (TOKEN_MAX),
      .DIM_BITS  (DIM_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .header_byte (req_tdata),
      .last_byte   (req_tlast),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.col_count, rsp_data_ff.row_count,
                        rsp_data_ff.element_type};
   assign rsp_tuser  = rsp_data_ff.dict_closed;

endmodule

>>> src/npyhdp_core.sv
// ----------------------------------------------------------------------------
// npyhdp_core
// Parse state of the header dictionary, updated by one byte per transfer.
// ----------------------------------------------------------------------------
module npyhdp_core #(
   parameter int unsigned TOKEN_MAX = 99,
   parameter int unsigned DIM_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             header_byte,
   input  logic                   last_byte,
   output npyhdp_pkg::result_type result
);

   localparam int unsigned TOK_W = $clog2(TOKEN_MAX + 1);

   localparam logic [1:0] SEG_EMPTY  = 2'd0;
   localparam logic [1:0] SEG_DIGITS = 2'd1;
   localparam logic [1:0] SEG_ENDED  = 2'd2;
   localparam logic [1:0] POS_START  = 2'd0;
   localparam logic [1:0] POS_LESS   = 2'd1;
   localparam logic [1:0] POS_LETTER = 2'd2;
   localparam logic [1:0] POS_EIGHT  = 2'd3;

   localparam logic [1:0] GUESS_NONE  = 2'd0;
   localparam logic [1:0] GUESS_MISS  = 2'd3;

   typedef enum logic [1:0] {
      MODE_WAIT  = 2'd0,
      MODE_KEY   = 2'd1,
      MODE_VALUE = 2'd2,
      MODE_DONE  = 2'd3
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic                     paren_ff, paren_in;
   logic [2:0]               kpos_ff, kpos_in;
   npyhdp_pkg::key_kind_type kind_ff, kind_in;
   logic [1:0]               vpos_ff, vpos_in;
   logic [1:0]               guess_ff, guess_in;
   logic [TOK_W-1:0]         tok_ff, tok_in;
   logic [DIM_BITS-1:0]      acc_ff, acc_in;
   logic [DIM_BITS-1:0]      prow_ff, prow_in;
   logic [DIM_BITS-1:0]      pcol_ff, pcol_in;
   logic [1:0]               type_ff, type_in;
   logic [DIM_BITS-1:0]      rows_ff, rows_in;
   logic [DIM_BITS-1:0]      cols_ff, cols_in;

   logic                     skip;
   logic                     room;
   logic [DIM_BITS+3:0]      acc_ext;
   logic [DIM_BITS-1:0]      seg_value;
   logic [DIM_BITS-1:0]      res_rows;
   logic [DIM_BITS-1:0]      res_cols;

   assign skip = (header_byte == npyhdp_pkg::CH_SPACE) || (header_byte == npyhdp_pkg::CH_QUOTE);
   assign room = tok_ff < TOK_W'(TOKEN_MAX);
   assign acc_ext = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                    + (DIM_BITS + 4)'(header_byte[3:0]);
   assign seg_value = (vpos_ff == SEG_EMPTY) ? DIM_BITS'(1) : acc_ff;

   always_comb begin
      mode_in  = mode_ff;
      paren_in = paren_ff;
      kpos_in  = kpos_ff;
      kind_in  = kind_ff;
      vpos_in  = vpos_ff;
      guess_in = guess_ff;
      tok_in   = tok_ff;
      acc_in   = acc_ff;
      prow_in  = prow_ff;
      pcol_in  = pcol_ff;
      type_in  = type_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      case (mode_ff)
         MODE_WAIT: begin
            if (header_byte == npyhdp_pkg::CH_LBRACE) begin
               mode_in = MODE_KEY;
               tok_in  = '0;
               kpos_in = 3'd0;
               kind_in = npyhdp_pkg::KIND_NONE;
            end
         end
         MODE_KEY: begin
            if (header_byte == npyhdp_pkg::CH_RBRACE) begin
               mode_in = MODE_DONE;
            end else if (header_byte == npyhdp_pkg::CH_COLON) begin
               if (!((kind_ff == npyhdp_pkg::KIND_DESCR || kind_ff == npyhdp_pkg::KIND_SHAPE)
                     && kpos_ff == 3'(npyhdp_pkg::KEY_LEN)
                     && tok_ff == TOK_W'(npyhdp_pkg::KEY_LEN))) begin
                  kind_in = npyhdp_pkg::KIND_NONE;
               end
               mode_in  = MODE_VALUE;
               tok_in   = '0;
               vpos_in  = SEG_EMPTY;
               guess_in = GUESS_NONE;
               acc_in   = '0;
               prow_in  = rows_ff;
               pcol_in  = cols_ff;
            end else if (!skip && room) begin
               tok_in = tok_ff + TOK_W'(1);
               if (kind_ff == npyhdp_pkg::KIND_NONE) begin
                  if (header_byte == npyhdp_pkg::key_byte(npyhdp_pkg::KIND_DESCR, 3'd0)) begin
                     kind_in = npyhdp_pkg::KIND_DESCR;
                  end else if (header_byte
                               == npyhdp_pkg::key_byte(npyhdp_pkg::KIND_SHAPE, 3'd0)) begin
                     kind_in = npyhdp_pkg::KIND_SHAPE;
                  end else begin
                     kind_in = npyhdp_pkg::KIND_MISS;
                  end
                  kpos_in = 3'd1;
               end else if (kind_ff != npyhdp_pkg::KIND_MISS) begin
                  if (kpos_ff < 3'(npyhdp_pkg::KEY_LEN)
                      && header_byte == npyhdp_pkg::key_byte(kind_ff, kpos_ff)) begin
                     kpos_in = kpos_ff + 3'd1;
                  end else begin
                     kind_in = npyhdp_pkg::KIND_MISS;
                  end
               end
            end
         end
         MODE_VALUE: begin
            if (header_byte == npyhdp_pkg::CH_COMMA && !paren_ff) begin
               if (kind_ff == npyhdp_pkg::KIND_DESCR) begin
                  if (guess_ff != GUESS_MISS && guess_ff != GUESS_NONE
                      && vpos_ff == POS_EIGHT) begin
                     type_in = guess_ff;
                  end
               end else if (kind_ff == npyhdp_pkg::KIND_SHAPE) begin
                  rows_in = prow_ff;
                  cols_in = pcol_ff;
               end
               mode_in = MODE_KEY;
               tok_in  = '0;
               kpos_in = 3'd0;
               kind_in = npyhdp_pkg::KIND_NONE;
            end else if (!skip) begin
               if (header_byte == npyhdp_pkg::CH_LPAREN) begin
                  paren_in = 1'b1;
               end else if (header_byte == npyhdp_pkg::CH_RPAREN) begin
                  paren_in = 1'b0;
               end
               if (room) begin
                  tok_in = tok_ff + TOK_W'(1);
                  if (kind_ff == npyhdp_pkg::KIND_DESCR && guess_ff != GUESS_MISS) begin
                     if (vpos_ff == POS_START && header_byte == npyhdp_pkg::CH_LESS) begin
                        vpos_in = POS_LESS;
                     end else if (vpos_ff == POS_LESS
                                  && header_byte == npyhdp_pkg::CH_LOW_I) begin
                        guess_in = npyhdp_pkg::ELEM_INT64;
                        vpos_in  = POS_LETTER;
                     end else if (vpos_ff == POS_LESS
                                  && header_byte == npyhdp_pkg::CH_LOW_F) begin
                        guess_in = npyhdp_pkg::ELEM_FLOAT64;
                        vpos_in  = POS_LETTER;
                     end else if (vpos_ff == POS_LETTER
                                  && header_byte == npyhdp_pkg::CH_EIGHT) begin
                        vpos_in = POS_EIGHT;
                     end else begin
                        guess_in = GUESS_MISS;
                     end
                  end else if (kind_ff == npyhdp_pkg::KIND_SHAPE
                               && header_byte != npyhdp_pkg::CH_LPAREN) begin
                     if (header_byte == npyhdp_pkg::CH_COMMA
                         || header_byte == npyhdp_pkg::CH_RPAREN) begin
                        if (header_byte == npyhdp_pkg::CH_COMMA) begin
                           prow_in = seg_value;
                        end else begin
                           pcol_in = seg_value;
                        end
                        acc_in  = '0;
                        vpos_in = SEG_EMPTY;
                     end else if (header_byte >= npyhdp_pkg::CH_ZERO
                                  && header_byte <= npyhdp_pkg::CH_NINE) begin
                        if (vpos_ff != SEG_ENDED) begin
                           if (acc_ext[DIM_BITS+3:DIM_BITS] != 4'd0) begin
                              acc_in = '1;
                           end else begin
                              acc_in = acc_ext[DIM_BITS-1:0];
                           end
                           vpos_in = SEG_DIGITS;
                        end
                     end else begin
                        vpos_in = SEG_ENDED;
                     end
                  end
               end
            end
         end
         MODE_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign res_rows = rows_in;
   assign res_cols = cols_in;

   generate
      if (DIM_BITS > 32) begin : g_sat
         assign result.row_count = (|res_rows[DIM_BITS-1:32]) ? 32'hFFFF_FFFF : res_rows[31:0];
         assign result.col_count = (|res_cols[DIM_BITS-1:32]) ? 32'hFFFF_FFFF : res_cols[31:0];
      end else begin : g_ext
         assign result.row_count = 32'(res_rows);
         assign result.col_count = 32'(res_cols);
      end
   endgenerate

   assign result.element_type = type_in;
   assign result.dict_closed  = (mode_in == MODE_DONE);

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         mode_ff  <= MODE_WAIT;
         paren_ff <= 1'b0;
         kpos_ff  <= 3'd0;
         kind_ff  <= npyhdp_pkg::KIND_NONE;
         vpos_ff  <= 2'd0;
         guess_ff <= GUESS_NONE;
         tok_ff   <= '0;
         acc_ff   <= '0;
         prow_ff  <= '0;
         pcol_ff  <= '0;
         type_ff  <= npyhdp_pkg::ELEM_UNKNOWN;
         rows_ff  <= '0;
         cols_ff  <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         paren_ff <= paren_in;
         kpos_ff  <= kpos_in;
         kind_ff  <= kind_in;
         vpos_ff  <= vpos_in;
         guess_ff <= guess_in;
         tok_ff   <= tok_in;
         acc_ff   <= acc_in;
         prow_ff  <= prow_in;
         pcol_ff  <= pcol_in;
         type_ff  <= type_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
      end
   end

endmodule
